// ===== design/gai_pkg.sv =====
// ----------------------------------------------------------------------------
// Gyro attitude integrator package
// Shared widths, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package gai_pkg;
   localparam int RateWidth   = 24;
   localparam int StampWidth  = 40;
   localparam int QuatWidth   = 16;
   localparam int AngleWidth  = 32;
   localparam int CordicSteps = 20;
   localparam int StepWidth   = 5;

   typedef logic signed [RateWidth-1:0]  rate_type;
   typedef logic        [StampWidth-1:0] stamp_type;
   typedef logic signed [QuatWidth-1:0]  quat_type;

   localparam logic signed [34:0] CordicGain  = 35'sd652032874;
   localparam logic signed [31:0] PhaseScale  = 32'sd1367130551;

   // Microseconds times 2^8 / 10^6 is times 4 over 15625. The quotient is
   // estimated with floor(2^44 / 15625) and then trimmed by the remainder.
   localparam logic [31:0] UsRecip   = 32'd1125899906;
   localparam logic [13:0] UsDivisor = 14'd15625;

   function automatic logic [29:0] atan_turn(input logic [StepWidth-1:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051E;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2F;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2FA;
         5'd15: v = 30'h0000517D;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A30;
         5'd19: v = 30'h00000518;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

// ===== design/gyro_attitude_integrator_top.sv =====
// ----------------------------------------------------------------------------
// Gyro attitude integrator
// Integrates gyro rates into three angles and emits the ZYX quaternion.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields                              Handshake
// req      in   rate_x/y/z (s24), stamp_us (u40)    req_valid / req_stall
// rsp      out  quat_x/y/z/w (s16, Q1.14)           rsp_valid / rsp_stall
//
// One sample is taken at a time; req_stall is high while the sequencer is busy.
// The first sample after reset only latches its stamp and leaves the sequencer
// idle. Each later sample keeps req_stall high while one shared 36x36
// multiplier serves three accumulations (one ends early when its increment
// saturates an angle outright), three phase scalings with CORDIC runs and
// twelve products; then the result beat is loaded.
// Reset is synchronous and active high and clears control and the angles.
// A result beat still stalled in the output register holds the sequencer in
// its last state until that beat is taken.
// ----------------------------------------------------------------------------
module gyro_attitude_integrator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gai_pkg::rate_type  req_rate_x,
   input  gai_pkg::rate_type  req_rate_y,
   input  gai_pkg::rate_type  req_rate_z,
   input  gai_pkg::stamp_type req_stamp_us,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gai_pkg::quat_type  rsp_quat_x,
   output gai_pkg::quat_type  rsp_quat_y,
   output gai_pkg::quat_type  rsp_quat_z,
   output gai_pkg::quat_type  rsp_quat_w
);
   import gai_pkg::*;

   // The sequencer walks these states. ACC handles one axis at a time in
   // six sub-steps; PHS scales an angle to a phase, COR runs CORDIC and fix-up;
   // MUL walks the product schedule one multiply a cycle.
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_ACC  = 6'b000010,
      S_PHS  = 6'b000100,
      S_COR  = 6'b001000,
      S_MUL  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic first_ff, first_in;
   stamp_type prev_ff, prev_in;
   logic signed [AngleWidth-1:0] ang_ff [3], ang_in [3];
   rate_type rate_ff [3], rate_in [3];
   stamp_type elapsed_ff, elapsed_in;
   logic [1:0] axis_ff, axis_in;
   logic [2:0] sub_ff, sub_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] quo_ff, quo_in;
   logic signed [35:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [32:0] cz_ff, cz_in;
   logic flip_ff, flip_in;
   logic signed [35:0] cs_ff [6], cs_in [6];   // cr sr cp sp cy sy
   logic signed [35:0] pp_ff [4], pp_in [4];   // crcp srsp srcp crsp
   logic signed [35:0] tt_ff [8], tt_in [8];
   logic [3:0] mi_ff, mi_in;
   logic out_valid_ff, out_valid_in;
   quat_type q_ff [4], q_in [4];

   // One multiplier serves every product. During accumulation it forms
   // mag*elapsed in two 24x20 halves, the quotient estimate and the
   // quotient times 15625; then the phase scaling and the quaternion terms.
   logic [23:0] mag;
   logic rate_neg;
   logic [16:0] rs;
   logic [34:0] inc;
   logic signed [71:0] mp;
   logic signed [35:0] ma, mb;
   logic signed [64:0] sumv;
   logic signed [35:0] dx, dy;
   logic [31:0] phase;
   logic signed [35:0] r36;
   logic acc_next;

   function automatic logic signed [15:0] to_q14(input logic signed [36:0] v);
      logic signed [36:0] r;
      r = (v + 37'sd32768) >>> 16;
      if (r > 37'sd16384) r = 37'sd16384;
      if (r < -37'sd16384) r = -37'sd16384;
      return r[15:0];
   endfunction

   always_comb begin
      rate_neg = rate_ff[axis_ff][RateWidth-1];
      mag = rate_neg ? 24'(-rate_ff[axis_ff]) : rate_ff[axis_ff];
      // Round the remainder part: (4*rem + 7812) / 15625 is 0 to 4.
      rs = 17'({prod_ff[13:0], 2'b00}) + 17'd7812;
      inc = 35'({quo_ff, 2'b00}) + 35'(rs >= 17'd15625) + 35'(rs >= 17'd31250)
            + 35'(rs >= 17'd46875) + 35'(rs >= 17'd62500);
      sumv = 65'(ang_ff[axis_ff]) + (rate_neg ? -65'(inc) : 65'(inc));
      ma = '0;
      mb = '0;
      case (state_ff)
         S_ACC: begin
            case (sub_ff)
               3'd0: begin ma = 36'(mag); mb = 36'(elapsed_ff[19:0]); end
               3'd1: begin ma = 36'(mag); mb = 36'(elapsed_ff[39:20]); end
               3'd2: begin ma = 36'(prod_ff[43:12]); mb = 36'(UsRecip); end
               3'd3: begin ma = 36'(quo_ff); mb = 36'(UsDivisor); end
               default: ;
            endcase
         end
         S_PHS: begin
            ma = 36'(ang_ff[axis_ff]);
            mb = 36'(PhaseScale);
         end
         S_MUL: begin
            case (mi_ff)
               4'd0:  begin ma = cs_ff[0]; mb = cs_ff[2]; end
               4'd1:  begin ma = cs_ff[1]; mb = cs_ff[3]; end
               4'd2:  begin ma = cs_ff[1]; mb = cs_ff[2]; end
               4'd3:  begin ma = cs_ff[0]; mb = cs_ff[3]; end
               4'd4:  begin ma = pp_ff[2]; mb = cs_ff[4]; end
               4'd5:  begin ma = pp_ff[3]; mb = cs_ff[5]; end
               4'd6:  begin ma = pp_ff[3]; mb = cs_ff[4]; end
               4'd7:  begin ma = pp_ff[2]; mb = cs_ff[5]; end
               4'd8:  begin ma = pp_ff[0]; mb = cs_ff[5]; end
               4'd9:  begin ma = pp_ff[1]; mb = cs_ff[4]; end
               4'd10: begin ma = pp_ff[0]; mb = cs_ff[4]; end
               default: begin ma = pp_ff[1]; mb = cs_ff[5]; end
            endcase
         end
         default: ;
      endcase
      mp = 72'(ma) * 72'(mb);
      r36 = 36'((mp + 72'sd536870912) >>> 30);
      phase = 32'((mp + 72'sd33554432) >>> 26);
      dx = cy_ff >>> step_ff;
      dy = cx_ff >>> step_ff;
   end

   always_comb begin
      state_in = state_ff; first_in = first_ff; prev_in = prev_ff;
      ang_in = ang_ff; rate_in = rate_ff; elapsed_in = elapsed_ff;
      axis_in = axis_ff; sub_in = sub_ff; step_in = step_ff;
      prod_in = prod_ff; quo_in = quo_ff; cx_in = cx_ff; cy_in = cy_ff;
      cz_in = cz_ff; flip_in = flip_ff; cs_in = cs_ff; pp_in = pp_ff;
      tt_in = tt_ff; mi_in = mi_ff; out_valid_in = out_valid_ff; q_in = q_ff;
      acc_next = 1'b0;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               prev_in = req_stamp_us;
               rate_in[0] = req_rate_x; rate_in[1] = req_rate_y;
               rate_in[2] = req_rate_z;
               elapsed_in = req_stamp_us - prev_ff;
               if (first_ff) first_in = 1'b0;
               else begin
                  state_in = S_ACC; axis_in = 2'd0; sub_in = 3'd0;
               end
            end
         end
         S_ACC: begin
            case (sub_ff)
               3'd0: begin prod_in = 64'(mp[43:0]); sub_in = 3'd1; end
               3'd1: begin prod_in = prod_ff + {mp[43:0], 20'd0}; sub_in = 3'd2; end
               3'd2: begin
                  // A product of 2^44 or more moves the angle by at least
                  // 2^32, so the sum saturates whatever the angle was.
                  if (prod_ff[63:44] != '0) begin
                     ang_in[axis_ff] = rate_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
                     acc_next = 1'b1;
                  end else begin
                     quo_in = mp[63:32]; sub_in = 3'd3;
                  end
               end
               3'd3: begin prod_in = prod_ff - mp[63:0]; sub_in = 3'd4; end
               3'd4: begin
                  // The estimate is low by at most two; trim the remainder.
                  if (prod_ff >= 64'(UsDivisor)) begin
                     prod_in = prod_ff - 64'(UsDivisor);
                     quo_in = quo_ff + 32'd1;
                  end else sub_in = 3'd5;
               end
               default: begin
                  ang_in[axis_ff] = (sumv > 65'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                                    (sumv < -65'sh80000000) ? 32'sh80000000 : sumv[31:0];
                  acc_next = 1'b1;
               end
            endcase
            if (acc_next) begin
               sub_in = 3'd0;
               if (axis_ff == 2'd2) begin state_in = S_PHS; axis_in = 2'd2; end
               else axis_in = axis_ff + 2'd1;
            end
         end
         S_PHS: begin
            // axis order for cs: roll(2)->0/1, pitch(0)->2/3, yaw(1)->4/5
            flip_in = phase[30] != phase[31];
            cz_in = 33'(signed'(phase[30] != phase[31] ? phase + 32'h80000000 : phase));
            cx_in = 36'(CordicGain); cy_in = '0; step_in = '0;
            state_in = S_COR;
         end
         S_COR: begin
            if (!cz_ff[32]) begin
               cx_in = cx_ff - dx; cy_in = cy_ff + dy;
               cz_in = cz_ff - 33'(atan_turn(step_ff));
            end else begin
               cx_in = cx_ff + dx; cy_in = cy_ff - dy;
               cz_in = cz_ff + 33'(atan_turn(step_ff));
            end
            step_in = step_ff + 1'b1;
            if (step_ff == StepWidth'(CordicSteps-1)) begin
               case (axis_ff)
                  2'd2: begin
                     cs_in[0] = flip_ff ? -cx_in : cx_in;
                     cs_in[1] = flip_ff ? -cy_in : cy_in;
                     axis_in = 2'd0; state_in = S_PHS;
                  end
                  2'd0: begin
                     cs_in[2] = flip_ff ? -cx_in : cx_in;
                     cs_in[3] = flip_ff ? -cy_in : cy_in;
                     axis_in = 2'd1; state_in = S_PHS;
                  end
                  default: begin
                     cs_in[4] = flip_ff ? -cx_in : cx_in;
                     cs_in[5] = flip_ff ? -cy_in : cy_in;
                     mi_in = '0; state_in = S_MUL;
                  end
               endcase
            end
         end
         S_MUL: begin
            if (mi_ff < 4'd4) pp_in[mi_ff[1:0]] = r36;
            else tt_in[3'(mi_ff - 4'd4)] = r36;
            mi_in = mi_ff + 4'd1;
            if (mi_ff == 4'd11) state_in = S_OUT;
         end
         S_OUT: begin
            // The output register is loaded only once the previous beat has
            // left, so a stalled beat never changes.
            if (!out_valid_ff || !rsp_stall) begin
               q_in[0] = to_q14(37'(tt_ff[0]) - 37'(tt_ff[1]));
               q_in[1] = to_q14(37'(tt_ff[2]) + 37'(tt_ff[3]));
               q_in[2] = to_q14(37'(tt_ff[4]) - 37'(tt_ff[5]));
               q_in[3] = to_q14(37'(tt_ff[6]) + 37'(tt_ff[7]));
               out_valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; first_ff <= 1'b1; prev_ff <= '0;
         ang_ff <= '{default: '0}; out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; first_ff <= first_in; prev_ff <= prev_in;
         ang_ff <= ang_in; out_valid_ff <= out_valid_in;
      end
      rate_ff <= rate_in; elapsed_ff <= elapsed_in; axis_ff <= axis_in;
      sub_ff <= sub_in; step_ff <= step_in; prod_ff <= prod_in; quo_ff <= quo_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; flip_ff <= flip_in;
      cs_ff <= cs_in; pp_ff <= pp_in; tt_ff <= tt_in; mi_ff <= mi_in; q_ff <= q_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = out_valid_ff;
   assign rsp_quat_x = q_ff[0];
   assign rsp_quat_y = q_ff[1];
   assign rsp_quat_z = q_ff[2];
   assign rsp_quat_w = q_ff[3];

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COR) |-> req_stall) else $error("accepted while busy");
   a_first_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && first_ff) |=> (state_ff == S_IDLE))
      else $error("first sample started work");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   a_out_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      $stable({rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w}))
      else $error("stalled result changed");
endmodule
